@@ src/cqvs_pkg.sv @@
// Package for the complex quintic value and slope block: word types,
// register indexes and the saturation helpers. No dependencies.
`timescale 1ns / 1ps

package cqvs_pkg;

   localparam int COEF_NUM = 6;

   localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [65:0] WIDE_MAX = 66'sd2147483647;
   localparam logic signed [65:0] WIDE_MIN = -66'sd2147483648;

   // The x^5 coefficient comes out of reset as 1.0 (Q16.16 real part).
   localparam logic [63:0] COEF_X5_RESET = 64'h0001_0000_0000_0000;

   typedef enum logic [2:0] {
      CSR_COEF_X5 = 3'd0,
      CSR_COEF_X4 = 3'd1,
      CSR_COEF_X3 = 3'd2,
      CSR_COEF_X2 = 3'd3,
      CSR_COEF_X1 = 3'd4,
      CSR_COEF_X0 = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] re;
      logic signed [31:0] im;
   } cplx_type;

   typedef struct packed {
      logic signed [31:0] point_re;
      logic signed [31:0] point_im;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] value_re;
      logic signed [31:0] value_im;
      logic signed [31:0] slope_re;
      logic signed [31:0] slope_im;
      logic               overflow;
   } rsp_word_type;

   typedef struct packed {
      logic signed [31:0] val;
      logic               ovf;
   } sat_type;

   // Clamp a wide signed value to 32 bits and report whether it clipped.
   function automatic sat_type sat_word(input logic signed [65:0] v);
      sat_type r;
      if (v > WIDE_MAX) begin
         r.val = WORD_MAX;
         r.ovf = 1'b1;
      end else if (v < WIDE_MIN) begin
         r.val = WORD_MIN;
         r.ovf = 1'b1;
      end else begin
         r.val = v[31:0];
         r.ovf = 1'b0;
      end
      return r;
   endfunction

   // Small constant scale of one part, saturated to 32 bits.
   function automatic sat_type scale_part(input logic signed [31:0] x,
                                          input logic [2:0] k);
      logic signed [65:0] ext;
      logic signed [65:0] wide;
      ext  = 66'(x);
      wide = ext * 66'(k);
      return sat_word(wide);
   endfunction

endpackage

@@ src/complex_quintic_value_and_slope.sv @@
// Evaluates a complex degree-5 polynomial and its derivative at one point per word, with
// the first word accepted the edge after a coefficient write already using the new values.
// A word accepted at one edge is loaded into the input register at that edge and then passes
// five Horner steps of three stages each (products, round and clamp, coefficient add) on its
// way to rsp; the derivative runs four steps alongside and is delayed to match. One word
// enters per cycle while rsp is not stalled. A stall on rsp freezes the whole pipeline
// and is passed straight back on req_stall.
// The coefficient port is always ready; coefficients must only be written while no word is in
// flight. Every part is signed fixed point with FRAC_BITS fraction bits, clamped on overflow.
// Depends on cqvs_pkg and cqvs_step.
`timescale 1ns / 1ps

module complex_quintic_value_and_slope import cqvs_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_data
);

   localparam int STEPS = 5;
   localparam int DEPTH = 3 * STEPS;

   // Coefficient registers.
   cplx_type coef_ff [0:COEF_NUM-1];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[CSR_COEF_X5] <= cplx_type'(COEF_X5_RESET);
         coef_ff[CSR_COEF_X4] <= '0;
         coef_ff[CSR_COEF_X3] <= '0;
         coef_ff[CSR_COEF_X2] <= '0;
         coef_ff[CSR_COEF_X1] <= '0;
         coef_ff[CSR_COEF_X0] <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_COEF_X5: coef_ff[CSR_COEF_X5] <= cplx_type'(csr_data);
            CSR_COEF_X4: coef_ff[CSR_COEF_X4] <= cplx_type'(csr_data);
            CSR_COEF_X3: coef_ff[CSR_COEF_X3] <= cplx_type'(csr_data);
            CSR_COEF_X2: coef_ff[CSR_COEF_X2] <= cplx_type'(csr_data);
            CSR_COEF_X1: coef_ff[CSR_COEF_X1] <= cplx_type'(csr_data);
            CSR_COEF_X0: coef_ff[CSR_COEF_X0] <= cplx_type'(csr_data);
            default: ;
         endcase
      end
   end

   // Derivative coefficients 5a, 4b, 3c and 2d, refreshed every cycle.
   cplx_type dcoef_in [0:3];
   cplx_type dcoef_ff [0:3];
   logic     dovf_in, dovf_ff;
   sat_type  scl_re [0:3];
   sat_type  scl_im [0:3];

   always_comb begin
      dovf_in = 1'b0;
      for (int i = 0; i < 4; i++) begin
         scl_re[i] = scale_part(coef_ff[i].re, 3'(STEPS - i));
         scl_im[i] = scale_part(coef_ff[i].im, 3'(STEPS - i));
         dcoef_in[i].re = scl_re[i].val;
         dcoef_in[i].im = scl_im[i].val;
         dovf_in = dovf_in | scl_re[i].ovf | scl_im[i].ovf;
      end
   end

   always_ff @(posedge clock) begin
      dcoef_ff <= dcoef_in;
      dovf_ff  <= dovf_in;
   end

   // Pipeline control: everything moves unless a finished word is held at the output.
   logic             advance;
   logic [DEPTH:0]   valid_ff;
   cplx_type         point_ff [0:DEPTH-3];

   assign advance   = !(valid_ff[DEPTH] && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[DEPTH-1:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         point_ff[0].re <= req_word.point_re;
         point_ff[0].im <= req_word.point_im;
         for (int i = 1; i <= DEPTH - 3; i++) begin
            point_ff[i] <= point_ff[i-1];
         end
      end
   end

   // Value lane: five steps with b, c, d, e, f.
   cplx_type acc_v [0:STEPS];
   logic     ovf_v [0:STEPS];

   assign acc_v[0] = coef_ff[CSR_COEF_X5];
   assign ovf_v[0] = 1'b0;

   // Slope lane: four steps with 4b, 3c, 2d, e.
   cplx_type acc_s [0:STEPS-1];
   logic     ovf_s [0:STEPS-1];

   assign acc_s[0] = dcoef_ff[0];
   assign ovf_s[0] = 1'b0;

   for (genvar k = 1; k <= STEPS; k++) begin : g_value
      cqvs_step #(.FRAC_BITS(FRAC_BITS)) u_step (
         .clock       (clock),
         .enable      (advance),
         .acc_in      (acc_v[k-1]),
         .acc_ovf_in  (ovf_v[k-1]),
         .point       (point_ff[3*(k-1)]),
         .coef        (coef_ff[k]),
         .acc_out     (acc_v[k]),
         .acc_ovf_out (ovf_v[k])
      );
   end

   for (genvar k = 1; k < STEPS; k++) begin : g_slope
      cplx_type step_coef;
      if (k < STEPS - 1) begin : g_scaled
         assign step_coef = dcoef_ff[k];
      end else begin : g_plain
         assign step_coef = coef_ff[k];
      end
      cqvs_step #(.FRAC_BITS(FRAC_BITS)) u_step (
         .clock       (clock),
         .enable      (advance),
         .acc_in      (acc_s[k-1]),
         .acc_ovf_in  (ovf_s[k-1]),
         .point       (point_ff[3*(k-1)]),
         .coef        (step_coef),
         .acc_out     (acc_s[k]),
         .acc_ovf_out (ovf_s[k])
      );
   end

   // The slope finishes one step early; hold it back to line up with the value.
   cplx_type slope_ff [0:2];
   logic     sovf_ff  [0:2];

   always_ff @(posedge clock) begin
      if (advance) begin
         slope_ff[0] <= acc_s[STEPS-1];
         sovf_ff[0]  <= ovf_s[STEPS-1];
         for (int i = 1; i < 3; i++) begin
            slope_ff[i] <= slope_ff[i-1];
            sovf_ff[i]  <= sovf_ff[i-1];
         end
      end
   end

   assign rsp_valid         = valid_ff[DEPTH];
   assign rsp_word.value_re = acc_v[STEPS].re;
   assign rsp_word.value_im = acc_v[STEPS].im;
   assign rsp_word.slope_re = slope_ff[2].re;
   assign rsp_word.slope_im = slope_ff[2].im;
   assign rsp_word.overflow = ovf_v[STEPS] | sovf_ff[2] | dovf_ff;

endmodule

@@ src/cqvs_step.sv @@
// One Horner step acc * z + coef on one complex lane, in three register stages.
// Depends on cqvs_pkg for the complex type and saturation.
`timescale 1ns / 1ps

module cqvs_step import cqvs_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic     clock,
   input  logic     enable,
   input  cplx_type acc_in,
   input  logic     acc_ovf_in,
   input  cplx_type point,
   input  cplx_type coef,
   output cplx_type acc_out,
   output logic     acc_ovf_out
);

   localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

   // Stage 1: the four partial products.
   logic signed [63:0] prod_rr_ff, prod_ii_ff, prod_ri_ff, prod_ir_ff;
   logic               ovf1_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_rr_ff <= acc_in.re * point.re;
         prod_ii_ff <= acc_in.im * point.im;
         prod_ri_ff <= acc_in.re * point.im;
         prod_ir_ff <= acc_in.im * point.re;
         ovf1_ff    <= acc_ovf_in;
      end
   end

   // Stage 2: combine, round half up, drop the fraction and clamp.
   logic signed [65:0] sum_re, sum_im, shift_re, shift_im;
   sat_type            mul_re, mul_im;
   cplx_type           mid_in, mid_ff;
   logic               ovf2_in, ovf2_ff;

   always_comb begin
      sum_re   = 66'(prod_rr_ff) - 66'(prod_ii_ff) + HALF;
      sum_im   = 66'(prod_ri_ff) + 66'(prod_ir_ff) + HALF;
      shift_re = sum_re >>> FRAC_BITS;
      shift_im = sum_im >>> FRAC_BITS;
      mul_re   = sat_word(shift_re);
      mul_im   = sat_word(shift_im);
      mid_in.re = mul_re.val;
      mid_in.im = mul_im.val;
      ovf2_in   = ovf1_ff | mul_re.ovf | mul_im.ovf;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mid_ff  <= mid_in;
         ovf2_ff <= ovf2_in;
      end
   end

   // Stage 3: add the coefficient and clamp again.
   logic signed [32:0] add_re, add_im;
   sat_type            fin_re, fin_im;
   cplx_type           acc_in_next, acc_ff;
   logic               ovf3_in, ovf3_ff;

   always_comb begin
      add_re = 33'(mid_ff.re) + 33'(coef.re);
      add_im = 33'(mid_ff.im) + 33'(coef.im);
      fin_re = sat_word(66'(add_re));
      fin_im = sat_word(66'(add_im));
      acc_in_next.re = fin_re.val;
      acc_in_next.im = fin_im.val;
      ovf3_in = ovf2_ff | fin_re.ovf | fin_im.ovf;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         acc_ff  <= acc_in_next;
         ovf3_ff <= ovf3_in;
      end
   end

   assign acc_out     = acc_ff;
   assign acc_ovf_out = ovf3_ff;

endmodule

@@ src/cqvs_checker.sv @@
// Port-level checks for the complex quintic value and slope block, bound to its top level.
// Depends on cqvs_pkg for the result word type.
`timescale 1ns / 1ps

module cqvs_checker import cqvs_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   // A stalled result word stays valid.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   // A stalled result word keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_word))
      else $error("result word changed while stalled");

   // The input side is held back only by a held result word.
   assert property (@(posedge clock)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a held result word");

   // Reset empties the pipeline.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid after reset");

endmodule

bind complex_quintic_value_and_slope cqvs_checker u_cqvs_checker (.*);
